>>> rtl/core/lcrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcrc_pkg
// Shared types and constants for the length-checked CRC receiver.
// ----------------------------------------------------------------------------
package lcrc_pkg;

    // Operation codes carried by each input transaction
    typedef enum logic [2:0] {
        OP_ARM    = 3'd0,
        OP_BEGIN  = 3'd1,
        OP_DATA   = 3'd2,
        OP_CLOSE  = 3'd3,
        OP_BREAK  = 3'd4,
        OP_CHECK  = 3'd5,
        OP_RESET  = 3'd6
    } op_t;

    // Verdict codes returned with each result
    typedef enum logic [2:0] {
        V_OK     = 3'd0,
        V_SMALL  = 3'd1,
        V_EMPTY  = 3'd2,
        V_OVER   = 3'd3,
        V_SHORT  = 3'd4,
        V_PHASE  = 3'd5,
        V_BROKEN = 3'd6
    } verdict_t;

    // Phase codes as reported on the result channel
    localparam logic [2:0] PC_IDLE  = 3'd0;
    localparam logic [2:0] PC_ARMED = 3'd1;
    localparam logic [2:0] PC_RECV  = 3'd2;
    localparam logic [2:0] PC_DONE  = 3'd3;
    localparam logic [2:0] PC_BROKE = 3'd4;

    // Internal phase state, one-hot
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_ARMED = 5'b00010,
        PH_RECV  = 5'b00100,
        PH_DONE  = 5'b01000,
        PH_BROKE = 5'b10000
    } phase_t;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Result of one transaction, handed from the control logic to the output register
    typedef struct packed {
        verdict_t    verdict;
        logic [2:0]  phase_code;
        logic [31:0] count;
        logic [31:0] crc;
    } result_t;

    // One-hot phase to reported code
    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        code = PC_IDLE;
        unique case (ph)
            PH_IDLE:  code = PC_IDLE;
            PH_ARMED: code = PC_ARMED;
            PH_RECV:  code = PC_RECV;
            PH_DONE:  code = PC_DONE;
            PH_BROKE: code = PC_BROKE;
            default:  code = PC_IDLE;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/core/lcrc_crc_byte.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcrc_crc_byte
// Byte-wide reflected CRC-32 update with pre and post inversion.
// ----------------------------------------------------------------------------
module lcrc_crc_byte (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [31:0] crc_out
);
    import lcrc_pkg::*;

    // Eight shift/xor steps, one per data bit, LSB first
    always_comb begin
        logic [31:0] c;
        c = ~crc_in ^ {24'd0, data_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = ~c;
    end

endmodule

>>> rtl/core/lcrc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcrc_ctrl
// Transfer phase control, byte counter and CRC accumulator.
// ----------------------------------------------------------------------------
module lcrc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic [2:0]            op,
    input  logic [31:0]           declared_length,
    input  logic [7:0]            data_byte,
    input  logic [31:0]           capacity,
    output lcrc_pkg::result_t     result
);
    import lcrc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] decl_reg, decl_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] crc_upd;
    verdict_t    verdict;

    lcrc_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (data_byte),
        .crc_out (crc_upd)
    );

    // Next state and verdict for the transaction in the input register
    always_comb begin
        phase_next = phase_reg;
        decl_next  = decl_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        verdict    = V_OK;
        case (op)
            OP_ARM: begin
                phase_next = PH_ARMED;
                decl_next  = '0;
                count_next = '0;
                crc_next   = '0;
            end
            OP_BEGIN: begin
                if (phase_reg == PH_BROKE) begin
                    verdict = V_BROKEN;
                end else if (phase_reg != PH_ARMED) begin
                    verdict = V_PHASE;
                end else if (declared_length == '0) begin
                    phase_next = PH_BROKE;
                    verdict    = V_EMPTY;
                end else if (declared_length > capacity) begin
                    phase_next = PH_BROKE;
                    verdict    = V_SMALL;
                end else begin
                    decl_next  = declared_length;
                    phase_next = PH_RECV;
                end
            end
            OP_DATA: begin
                if (phase_reg == PH_BROKE) begin
                    verdict = V_BROKEN;
                end else if (phase_reg != PH_RECV) begin
                    verdict = V_PHASE;
                end else if (count_reg == decl_reg) begin
                    // excess byte: not counted, not folded in
                    phase_next = PH_BROKE;
                    verdict    = V_OVER;
                end else begin
                    crc_next   = crc_upd;
                    count_next = count_reg + 32'd1;
                end
            end
            OP_CLOSE: begin
                if (phase_reg == PH_BROKE) begin
                    verdict = V_BROKEN;
                end else if (phase_reg != PH_RECV) begin
                    verdict = V_PHASE;
                end else if (count_reg != decl_reg) begin
                    phase_next = PH_BROKE;
                    verdict    = V_SHORT;
                end else begin
                    phase_next = PH_DONE;
                end
            end
            OP_BREAK: begin
                phase_next = PH_BROKE;
            end
            OP_CHECK: begin
                if (phase_reg == PH_BROKE) begin
                    verdict = V_BROKEN;
                end else if (phase_reg != PH_DONE) begin
                    verdict = V_PHASE;
                end
            end
            OP_RESET: begin
                phase_next = PH_IDLE;
                decl_next  = '0;
                count_next = '0;
                crc_next   = '0;
            end
            default: begin
                verdict = V_PHASE;
            end
        endcase
    end

    // Result reflects the state after this transaction
    assign result.verdict    = verdict;
    assign result.phase_code = phase_code(phase_next);
    assign result.count      = count_next;
    assign result.crc        = crc_next;

    // State update when the transaction moves to the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            decl_reg  <= '0;
            count_reg <= '0;
            crc_reg   <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            decl_reg  <= decl_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

endmodule

>>> rtl/core/length_checked_crc_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_checked_crc_receiver
// Length-checked transfer receiver with running CRC-32.
// ----------------------------------------------------------------------------
// Throughput is one transaction per clock cycle while m_ready holds; a transaction
// passes through an input register, then the result register, before its result
// appears on m_valid. The byte-wide CRC-32 update and the counter compare
// sit between those two registers, so the state is updated once per advancing
// transaction and the next transaction sees it immediately. Each input
// transaction gives exactly one result. The capacity register is written through
// cfg_we / cfg_wdata and should only be changed while no transaction is in flight.
module length_checked_crc_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [31:0] s_declared_length,
    input  logic [7:0]  s_data_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_verdict,
    output logic [2:0]  m_phase_now,
    output logic [31:0] m_received_count,
    output logic [31:0] m_running_crc
);
    import lcrc_pkg::*;

    logic        cap_we;
    logic [31:0] capacity_reg;

    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic [31:0] decl_reg;
    logic [7:0]  byte_reg;

    logic        out_valid_reg;
    result_t     out_reg;
    result_t     result;
    logic        advance;

    assign cap_we = cfg_we;

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= '0;
        end else if (cap_we) begin
            capacity_reg <= cfg_wdata;
        end
    end

    // Handshake: the input register empties whenever the output register can take a result
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_op;
            decl_reg <= s_declared_length;
            byte_reg <= s_data_byte;
        end
    end

    lcrc_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .op              (op_reg),
        .declared_length (decl_reg),
        .data_byte       (byte_reg),
        .capacity        (capacity_reg),
        .result          (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_verdict        = out_reg.verdict;
    assign m_phase_now      = out_reg.phase_code;
    assign m_received_count = out_reg.count;
    assign m_running_crc    = out_reg.crc;

    // A transaction leaving the input register always lands in the result register
    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("result lost after advance");

    // Input register may only hold when the result side is stalled
    a_hold_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |-> (m_valid && !m_ready))
        else $error("input register stalled without backpressure");

    // Failure verdicts that break the transfer must report the broken phase
    a_break_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_verdict == V_OVER || m_verdict == V_SHORT ||
                     m_verdict == V_EMPTY || m_verdict == V_SMALL))
        |-> (m_phase_now == PC_BROKE))
        else $error("breaking verdict without broken phase");

    // An arm transaction always yields ok, armed, zero count and zero CRC
    a_arm_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && op_reg == OP_ARM) |=>
        (m_verdict == V_OK && m_phase_now == PC_ARMED &&
         m_received_count == 32'd0 && m_running_crc == 32'd0))
        else $error("arm did not clear state");

endmodule
